[design/lhs_pkg.sv]
// Package for the lookahead heading steering block.
// Holds path depth, angle constants, command codes, state type and the CORDIC table.
`timescale 1ns / 1ps
package lhs_pkg;

	localparam int PATH_DEPTH = 256;
	localparam int AW = $clog2(PATH_DEPTH);
	localparam int LW = $clog2(PATH_DEPTH + 1);
	localparam int PW = 48;

	localparam int CORDIC_STEPS = 14;
	localparam int CW = 43;
	localparam int ZW = 17;

	localparam logic signed [ZW-1:0] ANG_PI      = 17'sd25736;
	localparam logic signed [ZW:0]   ANG_TWO_PI  = 18'sd51472;
	localparam logic signed [ZW:0]   ANG_HALF_PI = 18'sd12868;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_LOOKAHEAD = 2'd0,
		REG_LIMIT     = 2'd1,
		REG_GAIN      = 2'd2,
		REG_SPEED     = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_DIF,
		S_SQ,
		S_CMP,
		S_CORD,
		S_SEL,
		S_ERR,
		S_MULT,
		S_EMIT
	} state_t;

	function automatic logic [ZW-1:0] atan_step(input logic [3:0] i);
		logic [ZW-1:0] r;
		begin
			unique case (i)
				4'd0: r = 17'd6434;
				4'd1: r = 17'd3798;
				4'd2: r = 17'd2007;
				4'd3: r = 17'd1019;
				4'd4: r = 17'd511;
				4'd5: r = 17'd256;
				4'd6: r = 17'd128;
				4'd7: r = 17'd64;
				4'd8: r = 17'd32;
				4'd9: r = 17'd16;
				4'd10: r = 17'd8;
				4'd11: r = 17'd4;
				4'd12: r = 17'd2;
				4'd13: r = 17'd1;
				default: r = 17'd0;
			endcase
			return r;
		end
	endfunction

endpackage

[design/lhs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/lhs_cordic.sv]
// Iterative vectoring CORDIC giving atan2 in Q3.13, one rotation per cycle.
// Depends on lhs_pkg.
`timescale 1ns / 1ps
module lhs_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [24:0]          dx,
	input  logic signed [24:0]          dy,
	output logic                        done,
	output logic signed [lhs_pkg::ZW-1:0] angle
);
	import lhs_pkg::*;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [3:0]           cnt_q;
	logic                 busy_q, done_q;
	logic signed [CW-1:0] x0, y0, sx, sy;

	assign x0 = {{2{dx[24]}}, dx, 16'b0};
	assign y0 = {{2{dy[24]}}, dy, 16'b0};
	assign sx = x_q >>> cnt_q;
	assign sy = y_q >>> cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (dx == '0 && dy == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (y0 >= 0) ? ANG_PI : -ANG_PI;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + $signed(atan_step(cnt_q));
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - $signed(atan_step(cnt_q));
			end
		end
	end

	// The angle stays valid after done until the next start.
	assign done  = done_q;
	assign angle = z_q;
endmodule

[design/lookahead_heading_steering.sv]
// Top level of the lookahead heading steering block.
// Depends on lhs_pkg, lhs_ram and lhs_cordic.
`timescale 1ns / 1ps
// Usage: commands arrive as beats on the s_ channel (command code in s_tuser,
// point and pose fields in s_tdata). Every beat produces exactly one result
// beat on the m_ channel. Clear, append and unused commands go straight to
// S_EMIT, from which the result beat is registered. A pose query walks the
// stored path through the path RAM read port: each point passes S_RD, S_DIF,
// S_SQ, S_CMP and S_SEL, with a CORDIC run in S_CORD when it is at or beyond
// the lookahead distance; a final pass re-reads the chosen point, takes its
// bearing and forms the command. The path RAM port and the single iterative
// CORDIC set the query time. The block takes one command at a time; s_tready
// is high while it is idle, even when a finished result beat still waits on
// m_. If the receiver stalls, the finished result is held in the control
// logic until the output register frees, and no new beat is taken meanwhile.
// Reset empties the path and loads the register defaults; the path RAM itself
// is not cleared, since only entries below the path length are ever read.
// Registers are to be written through cfg_we only while idle; the block
// itself does not enforce this.
module lookahead_heading_steering (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, robot_x, robot_y, robot_heading
	input  logic [111:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// drive_speed, turn_rate, target_index, path_empty, path_overflow, zero fill
	output logic [55:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [22:0]  cfg_wdata
);
	import lhs_pkg::*;

	// Configuration registers.
	logic [22:0]        lookahead_q;
	logic [14:0]        limit_q;
	logic [15:0]        gain_q;
	logic signed [15:0] speed_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= 23'd256;
			limit_q     <= 15'd6434;
			gain_q      <= 16'd256;
			speed_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_LOOKAHEAD: lookahead_q <= cfg_wdata;
				REG_LIMIT:     limit_q     <= cfg_wdata[14:0];
				REG_GAIN:      gain_q      <= cfg_wdata[15:0];
				REG_SPEED:     speed_cfg_q <= cfg_wdata[15:0];
			endcase
		end
	end

	// Input fields.
	cmd_t               in_cmd;
	logic signed [23:0] in_px, in_py, in_rx, in_ry;
	logic signed [15:0] in_hd;
	assign in_cmd = cmd_t'(s_tuser);
	assign in_px  = s_tdata[23:0];
	assign in_py  = s_tdata[47:24];
	assign in_rx  = s_tdata[71:48];
	assign in_ry  = s_tdata[95:72];
	assign in_hd  = s_tdata[111:96];

	state_t state_q, state_d;
	logic   accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Path store: x in the low half, y in the high half of each word.
	logic [LW-1:0] len_q;
	logic          ram_we;
	logic [AW-1:0] raddr;
	logic [PW-1:0] rdata;

	assign ram_we = accept && in_cmd == CMD_APPEND && len_q < LW'(PATH_DEPTH);

	lhs_ram #(.WIDTH(PW), .DEPTH(PATH_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[AW-1:0]),
		.wdata ({in_py, in_px}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Query working registers.
	logic signed [23:0] rx_q, ry_q;
	logic signed [15:0] hd_q;
	logic [45:0]        lim2_q;
	logic [AW-1:0]      i_q, tidx_q, fidx_q, aidx_q;
	logic               final_q, fwd_q, any_q, far_q;
	logic signed [24:0] dx_q, dy_q;
	logic [49:0]        sqx_q, sqy_q;
	logic [50:0]        d2_q, best_f_q, best_a_q;
	logic signed [16:0] errc_q;
	logic signed [15:0] spd_q;
	logic signed [32:0] prod_q;
	logic               ovf_q;

	assign raddr = final_q ? tidx_q : i_q;

	// Bearing unit.
	logic               cord_start, cord_done;
	logic signed [ZW-1:0] cord_z;

	lhs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.dx     (dx_q),
		.dy     (dy_q),
		.done   (cord_done),
		.angle  (cord_z)
	);

	logic [50:0]        d2_sum;
	logic               last_pt;
	logic signed [ZW:0] diff_raw, diff_w1, diff_w2;
	logic               ahead;
	logic signed [ZW:0] err_raw, err_w;
	logic signed [ZW:0] lim_s;
	logic signed [ZW:0] abs_err;
	logic               out_free;

	assign d2_sum   = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign last_pt  = ({1'b0, i_q} + LW'(1)) == len_q;
	assign out_free = !m_tvalid || m_tready;

	// Target selection wraps the bearing difference twice in a row.
	assign diff_raw = {cord_z[ZW-1], cord_z} - 18'(hd_q);
	assign diff_w1  = (diff_raw > 18'(ANG_PI)) ? diff_raw - ANG_TWO_PI : diff_raw;
	assign diff_w2  = (diff_w1 < -18'(ANG_PI)) ? diff_w1 + ANG_TWO_PI : diff_w1;
	assign ahead    = diff_w2 < ANG_HALF_PI && diff_w2 > -ANG_HALF_PI;

	// The command error applies only one of the two corrections.
	assign err_raw = diff_raw;
	assign err_w   = (err_raw > 18'(ANG_PI))  ? err_raw - ANG_TWO_PI :
	                 (err_raw < -18'(ANG_PI)) ? err_raw + ANG_TWO_PI : err_raw;
	assign abs_err = (err_w < 0) ? -err_w : err_w;
	assign lim_s   = 18'({1'b0, limit_q});

	always_comb begin
		state_d    = state_q;
		cord_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_cmd == CMD_QUERY && len_q != '0) ? S_RD : S_EMIT;
				end
			end
			S_RD:   state_d = S_DIF;
			S_DIF:  state_d = S_SQ;
			S_SQ:   state_d = S_CMP;
			S_CMP: begin
				if (final_q || d2_sum >= {5'b0, lim2_q}) begin
					cord_start = 1'b1;
					state_d    = S_CORD;
				end else begin
					state_d = S_SEL;
				end
			end
			S_CORD: begin
				if (cord_done) begin
					state_d = final_q ? S_ERR : S_SEL;
				end
			end
			S_SEL:  state_d = S_RD;
			S_ERR:  state_d = S_MULT;
			S_MULT: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			m_tvalid <= 1'b0;
			final_q  <= 1'b0;
			fwd_q    <= 1'b0;
			any_q    <= 1'b0;
			i_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (accept) begin
				final_q <= 1'b0;
				fwd_q   <= 1'b0;
				any_q   <= 1'b0;
				i_q     <= '0;
				if (in_cmd == CMD_CLEAR) begin
					len_q <= '0;
				end else if (ram_we) begin
					len_q <= len_q + LW'(1);
				end
			end
			if (state_q == S_SEL) begin
				if (far_q) begin
					if (ahead && (!fwd_q || d2_q < best_f_q)) begin
						fwd_q <= 1'b1;
					end
					if (!any_q || d2_q < best_a_q) begin
						any_q <= 1'b1;
					end
				end
				if (last_pt) begin
					final_q <= 1'b1;
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
		end
	end

	logic [31:0] tidx_w;
	logic [15:0] gain_x;

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q   <= in_rx;
			ry_q   <= in_ry;
			hd_q   <= in_hd;
			lim2_q <= 46'(lookahead_q) * 46'(lookahead_q);
			fidx_q <= '0;
			aidx_q <= '0;
			tidx_q <= '0;
			ovf_q  <= (in_cmd == CMD_APPEND) && !ram_we;
			spd_q  <= '0;
			prod_q <= '0;
		end
		if (state_q == S_DIF) begin
			dx_q <= 25'(signed'(rdata[23:0])) - 25'(rx_q);
			dy_q <= 25'(signed'(rdata[47:24])) - 25'(ry_q);
		end
		if (state_q == S_SQ) begin
			sqx_q <= 50'(dx_q * dx_q);
			sqy_q <= 50'(dy_q * dy_q);
		end
		if (state_q == S_CMP) begin
			d2_q  <= d2_sum;
			far_q <= d2_sum >= {5'b0, lim2_q};
		end
		if (state_q == S_SEL) begin
			if (far_q) begin
				if (ahead && (!fwd_q || d2_q < best_f_q)) begin
					best_f_q <= d2_q;
					fidx_q   <= i_q;
				end
				if (!any_q || d2_q < best_a_q) begin
					best_a_q <= d2_q;
					aidx_q   <= i_q;
				end
			end
			if (last_pt) begin
				if (far_q && ahead && (!fwd_q || d2_q < best_f_q)) begin
					tidx_q <= i_q;
				end else if (fwd_q) begin
					tidx_q <= fidx_q;
				end else if (far_q && (!any_q || d2_q < best_a_q)) begin
					tidx_q <= i_q;
				end else begin
					tidx_q <= aidx_q;
				end
			end
		end
		if (state_q == S_ERR) begin
			spd_q <= (abs_err > lim_s) ? 16'sd0 : speed_cfg_q;
			if (err_w > lim_s) begin
				errc_q <= 17'(lim_s);
			end else if (err_w < -lim_s) begin
				errc_q <= 17'(-lim_s);
			end else begin
				errc_q <= 17'(err_w);
			end
		end
		if (state_q == S_MULT) begin
			prod_q <= 33'(errc_q) * signed'({17'b0, gain_x});
		end
	end

	assign gain_x = gain_q;
	assign tidx_w = 32'(tidx_q);

	// Result register, loaded once the previous beat has left.
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			m_tdata <= {6'b0, ovf_q, (len_q == '0), tidx_w[7:0], prod_q[31:8], spd_q};
		end
	end

	// The path never grows past the store depth.
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LW'(PATH_DEPTH))
		else $error("path length exceeds depth");

	// Every walk read addresses a stored point.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> {1'b0, raddr} < len_q)
		else $error("path read beyond stored length");

	// Every bearing request moves the controller into S_CORD.
	assert property (@(posedge clk) disable iff (!arst_n)
		cord_start |=> state_q == S_CORD)
		else $error("bearing request lost");
endmodule
